// ===== rtl/core/nls_pkg.sv =====
// Package for the numeric literal scanner: character codes, scan phases,
// base codes, result record and small digit helpers. No dependencies.
package nls_pkg;

  localparam int unsigned MAX_LITERAL_LENGTH = 1023;
  localparam int unsigned LenCapInt =
      (MAX_LITERAL_LENGTH < 1023) ? MAX_LITERAL_LENGTH : 1023;
  localparam logic [9:0] LEN_CAP = 10'(LenCapInt);

  localparam logic [7:0] CH_US    = 8'h5F;  // '_'
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_LO    = 8'h6F;
  localparam logic [7:0] CH_UO    = 8'h4F;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_UE    = 8'h45;
  localparam logic [7:0] CH_LP    = 8'h70;
  localparam logic [7:0] CH_UP    = 8'h50;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // error mark bit positions
  localparam int unsigned EM_FLOAT_BASE = 0;
  localparam int unsigned EM_HEX_MANT   = 1;
  localparam int unsigned EM_HEX_NOEXP  = 2;
  localparam int unsigned EM_P_SUFFIX   = 3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ZERO,
    PH_INT,
    PH_FRAC,
    PH_EXPS,
    PH_EXP
  } phase_e;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_BIN = 2'd1,
    BASE_OCT = 2'd2,
    BASE_HEX = 2'd3
  } base_e;

  typedef struct packed {
    logic       is_float;
    base_e      base_code;
    logic [9:0] length;
    logic [3:0] bad_digit_count;
    logic [3:0] err_marks;
  } result_t;

  // {valid, value} of a hex character
  function automatic logic [4:0] digit_val(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= CH_0 && c <= CH_9) begin
      r = {1'b1, 4'(c - CH_0)};
    end else if (c >= CH_LA && c <= CH_LF) begin
      r = {1'b1, 4'(c - CH_LA + 8'd10)};
    end else if (c >= CH_UA && c <= CH_UF) begin
      r = {1'b1, 4'(c - CH_UA + 8'd10)};
    end
    return r;
  endfunction

  // value not allowed in the base
  function automatic logic digit_over(input logic [3:0] v, input base_e b);
    logic r;
    case (b)
      BASE_DEC: r = (v >= 4'd10);
      BASE_BIN: r = (v >= 4'd2);
      BASE_OCT: r = (v >= 4'd8);
      default:  r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [9:0] len_bump(input logic [9:0] n);
    return (n < LEN_CAP) ? n + 10'd1 : n;
  endfunction

  function automatic logic [3:0] bad_bump(input logic [3:0] n);
    return (n != 4'hF) ? n + 4'd1 : n;
  endfunction

endpackage

// ===== rtl/core/nls_if.sv =====
// Handshake channels of the numeric literal scanner: source bytes in,
// literal results out. Depends on nothing.
interface nls_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       begin_req;

  modport source (output valid, ch, begin_req, input ready);
  modport sink   (input valid, ch, begin_req, output ready);
endinterface

interface nls_res_if;
  logic       valid;
  logic       ready;
  logic       is_float;
  logic [1:0] base_code;
  logic [9:0] length;
  logic [3:0] bad_digit_count;
  logic       err_float_base;
  logic       err_hex_mantissa;
  logic       err_hex_no_exponent;
  logic       err_p_suffix;

  modport source (output valid, is_float, base_code, length, bad_digit_count,
                  err_float_base, err_hex_mantissa, err_hex_no_exponent,
                  err_p_suffix, input ready);
  modport sink   (input valid, is_float, base_code, length, bad_digit_count,
                  err_float_base, err_hex_mantissa, err_hex_no_exponent,
                  err_p_suffix, output ready);
endinterface

// ===== rtl/core/numeric_literal_scanner.sv =====
// Numeric literal scanner: one source byte per request, one result request
// when the byte after a literal arrives. Depends on nls_pkg and nls_if.
//
// Throughput is one byte per cycle unless a waiting result stalls. A byte
// lands in an input register, the scan state is updated from it once the
// output register is free or being taken, and any result goes to the output
// register. The input register lets one more byte be taken while a result
// waits for its sink; after that, in_i.ready stays low until the result is
// taken. The byte that ends a literal is not counted and starts nothing
// unless it carries begin_req; begin_req within a literal closes it first.
module numeric_literal_scanner (
  input  logic clk_i,
  input  logic rst_ni,
  nls_in_if.sink    in_i,
  nls_res_if.source res_o
);
  import nls_pkg::*;

  // input register
  logic       in_valid_q;
  logic [7:0] ch_q;
  logic       begin_q;

  // scan state
  phase_e     phase_q, phase_d;
  base_e      base_q, base_d;
  logic [1:0] int_digits_q, int_digits_d;
  logic [9:0] count_q, count_d;
  logic       float_q, float_d;
  logic [3:0] bad_q, bad_d;
  logic [3:0] err_q, err_d;

  // output register
  logic       out_valid_q;
  result_t    res_q, res_d;

  logic       step;
  logic       emit;
  logic       res_from_q;
  logic       run_int, run_exp, try_exp;
  logic [4:0] dv;
  logic       is_us, is_e, is_p, is_digit;

  assign step       = in_valid_q && (!out_valid_q || res_o.ready);
  assign in_i.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ch_q    <= in_i.ch;
      begin_q <= in_i.begin_req;
    end
  end

  always_comb begin
    phase_d      = phase_q;
    base_d       = base_q;
    int_digits_d = int_digits_q;
    count_d      = count_q;
    float_d      = float_q;
    bad_d        = bad_q;
    err_d        = err_q;
    emit         = 1'b0;
    res_from_q   = 1'b0;
    run_int      = 1'b0;
    run_exp      = 1'b0;
    try_exp      = 1'b0;
    dv           = digit_val(ch_q);
    is_us        = (ch_q == CH_US);
    is_e         = (ch_q == CH_LE) || (ch_q == CH_UE);
    is_p         = (ch_q == CH_LP) || (ch_q == CH_UP);
    is_digit     = (ch_q >= CH_0) && (ch_q <= CH_9);

    if (step) begin
      if (!begin_q) begin
        case (phase_q)
          PH_ZERO: begin
            phase_d = PH_INT;
            if (ch_q == CH_LB || ch_q == CH_UB) begin
              base_d  = BASE_BIN;
              count_d = len_bump(count_q);
            end else if (ch_q == CH_LO || ch_q == CH_UO) begin
              base_d  = BASE_OCT;
              count_d = len_bump(count_q);
            end else if (ch_q == CH_LX || ch_q == CH_UX) begin
              base_d  = BASE_HEX;
              count_d = len_bump(count_q);
            end else begin
              // leading zero was a plain digit
              int_digits_d = 2'd1;
              run_int      = 1'b1;
            end
          end
          PH_INT: run_int = 1'b1;
          PH_FRAC: begin
            if (is_us) begin
              count_d = len_bump(count_q);
            end else if (dv[4] && !(digit_over(dv[3:0], base_q) && is_e)) begin
              if (digit_over(dv[3:0], base_q)) bad_d = bad_bump(bad_q);
              count_d = len_bump(count_q);
            end else begin
              if (base_q == BASE_BIN || base_q == BASE_OCT) err_d[EM_FLOAT_BASE] = 1'b1;
              if (base_q == BASE_HEX) begin
                if (int_digits_q != 2'd1) err_d[EM_HEX_MANT] = 1'b1;
                if (!is_p) err_d[EM_HEX_NOEXP] = 1'b1;
              end
              try_exp = 1'b1;
            end
          end
          PH_EXPS: begin
            phase_d = PH_EXP;
            if (ch_q == CH_PLUS || ch_q == CH_MINUS) begin
              count_d = len_bump(count_q);
            end else begin
              run_exp = 1'b1;
            end
          end
          PH_EXP: run_exp = 1'b1;
          default: phase_d = PH_IDLE;
        endcase

        if (run_int) begin
          if (is_us) begin
            count_d = len_bump(count_q);
          end else if (dv[4] && !(digit_over(dv[3:0], base_q) && is_e)) begin
            if (digit_over(dv[3:0], base_q)) bad_d = bad_bump(bad_q);
            if (int_digits_d != 2'd3) int_digits_d = int_digits_d + 2'd1;
            count_d = len_bump(count_q);
          end else if (ch_q == CH_DOT) begin
            float_d = 1'b1;
            count_d = len_bump(count_q);
            phase_d = PH_FRAC;
          end else begin
            try_exp = 1'b1;
          end
        end

        if (run_exp) begin
          if (is_us) begin
            count_d = len_bump(count_q);
          end else if (dv[4] && !(digit_over(dv[3:0], BASE_DEC) && is_e)) begin
            if (digit_over(dv[3:0], BASE_DEC)) bad_d = bad_bump(bad_q);
            count_d = len_bump(count_q);
          end else begin
            emit    = 1'b1;
            phase_d = PH_IDLE;
          end
        end

        if (try_exp) begin
          if (is_e || is_p) begin
            float_d = 1'b1;
            if (is_p && base_q != BASE_HEX) err_d[EM_P_SUFFIX] = 1'b1;
            count_d = len_bump(count_q);
            phase_d = PH_EXPS;
          end else begin
            emit    = 1'b1;
            phase_d = PH_IDLE;
          end
        end
      end else begin
        // begin request: close a running literal, then maybe start anew
        if (phase_q != PH_IDLE) begin
          emit       = 1'b1;
          res_from_q = 1'b1;
        end
        phase_d = PH_IDLE;
        if (is_digit) begin
          base_d       = BASE_DEC;
          float_d      = 1'b0;
          bad_d        = '0;
          err_d        = '0;
          count_d      = len_bump('0);
          int_digits_d = (ch_q == CH_0) ? 2'd0 : 2'd1;
          phase_d      = (ch_q == CH_0) ? PH_ZERO : PH_INT;
        end
      end
    end

    if (res_from_q) begin
      res_d = '{is_float: float_q, base_code: base_q, length: count_q,
                bad_digit_count: bad_q, err_marks: err_q};
    end else begin
      res_d = '{is_float: float_d, base_code: base_d, length: count_d,
                bad_digit_count: bad_d, err_marks: err_d};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      base_q       <= BASE_DEC;
      int_digits_q <= '0;
      count_q      <= '0;
      float_q      <= 1'b0;
      bad_q        <= '0;
      err_q        <= '0;
    end else begin
      phase_q      <= phase_d;
      base_q       <= base_d;
      int_digits_q <= int_digits_d;
      count_q      <= count_d;
      float_q      <= float_d;
      bad_q        <= bad_d;
      err_q        <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && emit) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid               = out_valid_q;
  assign res_o.is_float            = res_q.is_float;
  assign res_o.base_code           = 2'(res_q.base_code);
  assign res_o.length              = res_q.length;
  assign res_o.bad_digit_count     = res_q.bad_digit_count;
  assign res_o.err_float_base      = res_q.err_marks[EM_FLOAT_BASE];
  assign res_o.err_hex_mantissa    = res_q.err_marks[EM_HEX_MANT];
  assign res_o.err_hex_no_exponent = res_q.err_marks[EM_HEX_NOEXP];
  assign res_o.err_p_suffix        = res_q.err_marks[EM_P_SUFFIX];

endmodule

// ===== rtl/core/nls_checker.sv =====
// Port-level checks for numeric_literal_scanner, attached by bind.
// Depends on nls_pkg and the nls_if channels of the top level.
module nls_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic       res_is_float_i,
  input logic [1:0] res_base_code_i,
  input logic [9:0] res_length_i,
  input logic       res_err_hex_mantissa_i,
  input logic       res_err_p_suffix_i
);
  import nls_pkg::*;

  // a waiting result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result request dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_length_i) && $stable(res_base_code_i))
    else $error("result payload changed while stalled");

  // input back-pressure only when the result side is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> res_valid_i && !res_ready_i)
    else $error("input stalled without a waiting result");

  // length in 1..LEN_CAP; p mark implies float, mantissa mark hex float
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> res_length_i != 10'd0 && res_length_i <= LEN_CAP &&
                    (!res_err_hex_mantissa_i ||
                     (res_base_code_i == 2'(BASE_HEX) && res_is_float_i)) &&
                    (!res_err_p_suffix_i || res_is_float_i))
    else $error("inconsistent result fields");

endmodule

bind numeric_literal_scanner nls_checker u_nls_checker (
  .clk_i                  (clk_i),
  .rst_ni                 (rst_ni),
  .in_valid_i             (in_i.valid),
  .in_ready_i             (in_i.ready),
  .res_valid_i            (res_o.valid),
  .res_ready_i            (res_o.ready),
  .res_is_float_i         (res_o.is_float),
  .res_base_code_i        (res_o.base_code),
  .res_length_i           (res_o.length),
  .res_err_hex_mantissa_i (res_o.err_hex_mantissa),
  .res_err_p_suffix_i     (res_o.err_p_suffix)
);
